>>> hdl/sqd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Smallest-three quaternion dequantizer: shared definitions
// Widths of the fixed-point intermediates, the sqrt(1/2) constant and the
// control word that travels down the pipeline next to the data.
// ----------------------------------------------------------------------------
package sqd_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   // Magnitude of coarse*256 + fine*scale never exceeds 17408.
   localparam int NMAG_W = 15;
   localparam int K_W    = 32;
   localparam logic [K_W-1:0] SQRT_HALF_Q32 = 32'hB504_F334;

   // |N| * K in Q.46 stays below 2^46.
   localparam int MAG_W = 46;
   localparam int C30_W = 30;
   localparam int SQ_W  = 2 * C30_W;
   localparam int SUM_W = SQ_W + 2;
   localparam int REM_W = 61;

   typedef enum logic [1:0] {
      DROP_X = 2'd0,
      DROP_Y = 2'd1,
      DROP_Z = 2'd2,
      DROP_W = 2'd3
   } drop_type;

   typedef struct packed {
      logic     valid;
      drop_type drop;
   } ctl_type;

endpackage
`default_nettype wire

>>> hdl/sqd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Front end: decode, scale and square
// Seven stages: decode, multiply by sqrt(1/2), round, square, two-step sum,
// and the remainder 1 - sum of squares that feeds the square root.
// ----------------------------------------------------------------------------
module sqd_front #(
   parameter int FRAC_BITS = sqd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sqd_pkg::ctl_type           in_ctl,
   input  logic [2:0][7:0]            prefix,
   input  logic [2:0][7:0]            fine,
   output sqd_pkg::ctl_type           out_ctl,
   output logic [2:0][FRAC_BITS+1:0]  kept,
   output logic [2*FRAC_BITS+2:0]     radicand
);
   import sqd_pkg::*;

   localparam int OUT_W         = FRAC_BITS + 2;
   localparam int KEPT_SH       = MAG_W - FRAC_BITS;
   localparam int C30_SH        = MAG_W - C30_W;
   localparam int RAD_W         = 2 * FRAC_BITS + 3;
   localparam int RAD_LSB       = REM_W - RAD_W;
   localparam int FRONT_STAGES  = 7;
   localparam logic [MAG_W:0]   KEPT_HALF = (MAG_W+1)'(1) << (KEPT_SH - 1);
   localparam logic [MAG_W:0]   C30_HALF  = (MAG_W+1)'(1) << (C30_SH - 1);
   localparam logic [SUM_W-1:0] ONE_Q60   = SUM_W'(1) << (REM_W - 1);

   ctl_type ctl_ff [FRONT_STAGES];

   // Stage registers; the lane arrays hold one entry per kept lane.
   logic [2:0]                s1_sign_ff, s2_sign_ff, s3_sign_ff;
   logic [2:0][NMAG_W-1:0]    s1_mag_ff;
   logic [2:0][NMAG_W-1:0]    s1_mag_in;
   logic [2:0][MAG_W-1:0]     s2_prod_ff, s2_prod_in;
   logic [2:0][FRAC_BITS:0]   s3_kmag_ff, s3_kmag_in;
   logic [2:0][C30_W-1:0]     s3_c30_ff, s3_c30_in;
   logic [2:0][OUT_W-1:0]     s4_kept_ff, s4_kept_in;
   logic [2:0][SQ_W-1:0]      s4_sq_ff, s4_sq_in;
   logic [2:0][OUT_W-1:0]     s5_kept_ff, s6_kept_ff, s7_kept_ff;
   logic [SUM_W-1:0]          s5_sum_ff, s5_sum_in;
   logic [SQ_W-1:0]           s5_sq_ff;
   logic [SUM_W-1:0]          s6_total_ff, s6_total_in;
   logic [RAD_W-1:0]          s7_rad_ff, s7_rad_in;
   logic [2:0]                s1_sign_in;

   always_comb begin
      logic signed [15:0]              n;
      logic [15:0]                     nabs;
      logic [NMAG_W+K_W-1:0]           prod;
      logic [MAG_W:0]                  kround;
      logic [MAG_W:0]                  cround;
      logic [OUT_W-1:0]                kext;
      logic [SUM_W-1:0]                diff;
      for (int i = 0; i < 3; i++) begin
         // Coarse value sits eight bits up; the flag scales the fine entry by 8.
         n = $signed({prefix[i][6], prefix[i][6:0], 8'h00})
           + (prefix[i][7] ? $signed({{5{fine[i][7]}}, fine[i], 3'b000})
                           : $signed({{8{fine[i][7]}}, fine[i]}));
         nabs = n[15] ? 16'(-n) : 16'(n);
         s1_sign_in[i] = n[15];
         s1_mag_in[i]  = nabs[NMAG_W-1:0];

         prod = (NMAG_W+K_W)'(s1_mag_ff[i]) * (NMAG_W+K_W)'(SQRT_HALF_Q32);
         s2_prod_in[i] = prod[MAG_W-1:0];

         kround = {1'b0, s2_prod_ff[i]} + KEPT_HALF;
         cround = {1'b0, s2_prod_ff[i]} + C30_HALF;
         s3_kmag_in[i] = kround[MAG_W:KEPT_SH];
         s3_c30_in[i]  = cround[C30_SH+C30_W-1:C30_SH];

         kext = {1'b0, s3_kmag_ff[i]};
         s4_kept_in[i] = s3_sign_ff[i] ? (~kext + 1'b1) : kext;
         s4_sq_in[i]   = SQ_W'(s3_c30_ff[i]) * SQ_W'(s3_c30_ff[i]);
      end

      s5_sum_in   = SUM_W'(s4_sq_ff[0]) + SUM_W'(s4_sq_ff[1]);
      s6_total_in = s5_sum_ff + SUM_W'(s5_sq_ff);

      // A negative remainder means the dropped component is zero.
      diff = ONE_Q60 - s6_total_ff;
      s7_rad_in = (s6_total_ff < ONE_Q60) ? diff[REM_W-1:RAD_LSB] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < FRONT_STAGES; s++) begin
            ctl_ff[s] <= '0;
         end
      end else begin
         ctl_ff[0] <= in_ctl;
         for (int s = 1; s < FRONT_STAGES; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_sign_ff  <= s1_sign_in;
      s1_mag_ff   <= s1_mag_in;
      s2_sign_ff  <= s1_sign_ff;
      s2_prod_ff  <= s2_prod_in;
      s3_sign_ff  <= s2_sign_ff;
      s3_kmag_ff  <= s3_kmag_in;
      s3_c30_ff   <= s3_c30_in;
      s4_kept_ff  <= s4_kept_in;
      s4_sq_ff    <= s4_sq_in;
      s5_kept_ff  <= s4_kept_ff;
      s5_sum_ff   <= s5_sum_in;
      s5_sq_ff    <= s4_sq_ff[2];
      s6_kept_ff  <= s5_kept_ff;
      s6_total_ff <= s6_total_in;
      s7_kept_ff  <= s6_kept_ff;
      s7_rad_ff   <= s7_rad_in;
   end

   assign out_ctl  = ctl_ff[FRONT_STAGES-1];
   assign kept     = s7_kept_ff;
   assign radicand = s7_rad_ff;

endmodule
`default_nettype wire

>>> hdl/sqd_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage. The radicand
// carries two extra fraction bits so that the root has one bit past the
// output precision for rounding. The kept components ride along.
// ----------------------------------------------------------------------------
module sqd_sqrt #(
   parameter int FRAC_BITS = sqd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sqd_pkg::ctl_type           in_ctl,
   input  logic [2:0][FRAC_BITS+1:0]  in_kept,
   input  logic [2*FRAC_BITS+2:0]     radicand,
   output sqd_pkg::ctl_type           out_ctl,
   output logic [2:0][FRAC_BITS+1:0]  out_kept,
   output logic [FRAC_BITS+1:0]       root
);
   import sqd_pkg::*;

   localparam int ROOT_W = FRAC_BITS + 2;
   localparam int OUT_W  = FRAC_BITS + 2;
   localparam int RAD_PW = 2 * ROOT_W;
   localparam int REMW   = ROOT_W + 2;
   localparam int RPW    = ROOT_W + 4;

   ctl_type                ctl_ff  [ROOT_W];
   logic [2:0][OUT_W-1:0]  kept_ff [ROOT_W];
   logic [RAD_PW-1:0]      rad_ff  [ROOT_W];
   logic [RAD_PW-1:0]      rad_in  [ROOT_W];
   logic [REMW-1:0]        rem_ff  [ROOT_W];
   logic [REMW-1:0]        rem_in  [ROOT_W];
   logic [ROOT_W-1:0]      root_ff [ROOT_W];
   logic [ROOT_W-1:0]      root_in [ROOT_W];

   always_comb begin
      logic [RAD_PW-1:0] rad_prev;
      logic [REMW-1:0]   rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RPW-1:0]    rp;
      logic [RPW-1:0]    trial;
      logic [RPW-1:0]    diff;
      logic              ge;
      for (int s = 0; s < ROOT_W; s++) begin
         if (s == 0) begin
            rad_prev  = {1'b0, radicand};
            rem_prev  = '0;
            root_prev = '0;
         end else begin
            rad_prev  = rad_ff[s-1];
            rem_prev  = rem_ff[s-1];
            root_prev = root_ff[s-1];
         end
         // Bring down the next two radicand bits and try the bit 4*root+1.
         rp    = {rem_prev, rad_prev[RAD_PW-1 -: 2]};
         trial = {2'b00, root_prev, 2'b01};
         ge    = (rp >= trial);
         diff  = rp - trial;
         rad_in[s]  = rad_prev << 2;
         rem_in[s]  = ge ? diff[REMW-1:0] : rp[REMW-1:0];
         root_in[s] = {root_prev[ROOT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ROOT_W; s++) begin
            ctl_ff[s] <= '0;
         end
      end else begin
         ctl_ff[0] <= in_ctl;
         for (int s = 1; s < ROOT_W; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      kept_ff[0] <= in_kept;
      for (int s = 1; s < ROOT_W; s++) begin
         kept_ff[s] <= kept_ff[s-1];
      end
      for (int s = 0; s < ROOT_W; s++) begin
         rad_ff[s]  <= rad_in[s];
         rem_ff[s]  <= rem_in[s];
         root_ff[s] <= root_in[s];
      end
   end

   assign out_ctl  = ctl_ff[ROOT_W-1];
   assign out_kept = kept_ff[ROOT_W-1];
   assign root     = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

>>> hdl/sqd_place.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Output stage: round the root and place the components
// Halves the extended root with rounding, puts it in the dropped slot and
// the kept components in the other slots in x, y, z, w order.
// ----------------------------------------------------------------------------
module sqd_place #(
   parameter int FRAC_BITS = sqd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sqd_pkg::ctl_type           in_ctl,
   input  logic [2:0][FRAC_BITS+1:0]  kept,
   input  logic [FRAC_BITS+1:0]       root,
   output logic                       out_valid,
   output logic [FRAC_BITS+1:0]       quat_x,
   output logic [FRAC_BITS+1:0]       quat_y,
   output logic [FRAC_BITS+1:0]       quat_z,
   output logic [FRAC_BITS+1:0]       quat_w
);
   import sqd_pkg::*;

   localparam int OUT_W  = FRAC_BITS + 2;
   localparam int ROOT_W = FRAC_BITS + 2;

   logic             valid_ff;
   logic [OUT_W-1:0] x_ff, y_ff, z_ff, w_ff;
   logic [OUT_W-1:0] x_in, y_in, z_in, w_in;

   always_comb begin
      logic [ROOT_W-1:0] rsum;
      logic [OUT_W-1:0]  dropped;
      // The root carries one extra bit; adding one then halving rounds it.
      rsum    = root + 1'b1;
      dropped = OUT_W'(rsum[ROOT_W-1:1]);
      unique case (in_ctl.drop)
         DROP_X: begin
            x_in = dropped; y_in = kept[0]; z_in = kept[1]; w_in = kept[2];
         end
         DROP_Y: begin
            x_in = kept[0]; y_in = dropped; z_in = kept[1]; w_in = kept[2];
         end
         DROP_Z: begin
            x_in = kept[0]; y_in = kept[1]; z_in = dropped; w_in = kept[2];
         end
         DROP_W: begin
            x_in = kept[0]; y_in = kept[1]; z_in = kept[2]; w_in = dropped;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      w_ff <= w_in;
   end

   assign out_valid = valid_ff;
   assign quat_x    = x_ff;
   assign quat_y    = y_ff;
   assign quat_z    = z_ff;
   assign quat_w    = w_ff;

endmodule
`default_nettype wire

>>> hdl/smallest_three_quat_dequant_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Smallest-three quaternion dequantizer
// Turns one packed rotation key into four Q.FRAC_BITS quaternion components,
// rebuilding the dropped component from the unit-norm constraint.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   start / busy     req_prefix_first..mode, req_fine_first..third
//  response  rsp_valid        rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w
//
// A new key is taken every cycle while busy is low. Most of the pipeline is
// the square root, which resolves one root bit per stage; seven stages in
// front decode, scale, square, sum and form the remainder. busy is high while
// reset is held and in the first cycle after it. The pipeline never stalls,
// and reset clears every valid bit in flight.
// ----------------------------------------------------------------------------
module smallest_three_quat_dequant_core #(
   parameter int FRAC_BITS = sqd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [7:0]           req_prefix_first,
   input  logic [7:0]           req_prefix_second,
   input  logic [7:0]           req_prefix_third,
   input  logic [7:0]           req_prefix_mode,
   input  logic signed [7:0]    req_fine_first,
   input  logic signed [7:0]    req_fine_second,
   input  logic signed [7:0]    req_fine_third,
   output logic                 rsp_valid,
   output logic [FRAC_BITS+1:0] rsp_quat_x,
   output logic [FRAC_BITS+1:0] rsp_quat_y,
   output logic [FRAC_BITS+1:0] rsp_quat_z,
   output logic [FRAC_BITS+1:0] rsp_quat_w
);
   import sqd_pkg::*;

   localparam int OUT_W = FRAC_BITS + 2;

   logic                   busy_ff;
   ctl_type                in_ctl;
   ctl_type                front_ctl;
   ctl_type                root_ctl;
   logic [2:0][7:0]        prefix;
   logic [2:0][7:0]        fine;
   logic [2:0][OUT_W-1:0]  front_kept;
   logic [2:0][OUT_W-1:0]  root_kept;
   logic [2*FRAC_BITS+2:0] radicand;
   logic [OUT_W-1:0]       root;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   // The low six mode bits hold a repeat count that is not used here.
   assign in_ctl.valid = start & ~busy_ff;
   assign in_ctl.drop  = drop_type'(req_prefix_mode[7:6]);
   assign prefix = {req_prefix_third, req_prefix_second, req_prefix_first};
   assign fine   = {req_fine_third, req_fine_second, req_fine_first};

   sqd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (in_ctl),
      .prefix   (prefix),
      .fine     (fine),
      .out_ctl  (front_ctl),
      .kept     (front_kept),
      .radicand (radicand)
   );

   sqd_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (front_ctl),
      .in_kept  (front_kept),
      .radicand (radicand),
      .out_ctl  (root_ctl),
      .out_kept (root_kept),
      .root     (root)
   );

   sqd_place #(.FRAC_BITS(FRAC_BITS)) u_place (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (root_ctl),
      .kept      (root_kept),
      .root      (root),
      .out_valid (rsp_valid),
      .quat_x    (rsp_quat_x),
      .quat_y    (rsp_quat_y),
      .quat_z    (rsp_quat_z),
      .quat_w    (rsp_quat_w)
   );

endmodule
`default_nettype wire

>>> hdl/sqd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker for the quaternion dequantizer
// Watches latency, reset behavior and the range of the result components.
// ----------------------------------------------------------------------------
module sqd_checker #(
   parameter int FRAC_BITS = sqd_pkg::FRAC_BITS_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [FRAC_BITS+1:0] rsp_quat_x,
   input logic [FRAC_BITS+1:0] rsp_quat_y,
   input logic [FRAC_BITS+1:0] rsp_quat_z,
   input logic [FRAC_BITS+1:0] rsp_quat_w
);
   localparam int OUT_W   = FRAC_BITS + 2;
   localparam int LATENCY = FRAC_BITS + 10;
   localparam logic signed [OUT_W-1:0] ONE     = OUT_W'(1) << FRAC_BITS;
   localparam logic signed [OUT_W-1:0] NEG_ONE = -ONE;

   // Every accepted beat comes out a fixed number of cycles later.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted beat did not produce a result on time");

   // No result without a beat accepted that many cycles before.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching request");

   // Reset flushes the pipeline and then opens the request side.
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_reset_open: assert property (@(posedge clock)
      (!reset && !$past(reset)) |-> !busy)
      else $error("busy held after reset");

   // Components of a unit quaternion stay within plus or minus one.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ($signed(rsp_quat_x) <= ONE) && ($signed(rsp_quat_x) >= NEG_ONE) &&
         ($signed(rsp_quat_y) <= ONE) && ($signed(rsp_quat_y) >= NEG_ONE) &&
         ($signed(rsp_quat_z) <= ONE) && ($signed(rsp_quat_z) >= NEG_ONE) &&
         ($signed(rsp_quat_w) <= ONE) && ($signed(rsp_quat_w) >= NEG_ONE))
      else $error("quaternion component out of range");

endmodule

bind smallest_three_quat_dequant_core sqd_checker #(.FRAC_BITS(FRAC_BITS)) u_sqd_checker (.*);
`default_nettype wire

>>> sim/tb_smallest_three_quat_dequant_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Testbench: smallest-three quaternion dequantizer core
// Sends packed rotation keys through the start/busy port, first from a short
// table of edge cases, then at random with random gaps. Each key's result is
// predicted in the bench and compared field by field with the rsp_ beat.
// ----------------------------------------------------------------------------
module tb_smallest_three_quat_dequant_core;
   import sqd_pkg::*;

   localparam int FRAC     = FRAC_BITS_DEFAULT;
   localparam int OW       = FRAC + 2;
   localparam int KEPT_SH  = 46 - FRAC;
   localparam int ROOT_SH  = 2 * (30 - FRAC);
   localparam int LATENCY  = FRAC + 10;
   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_KEYS = 1030;
   localparam int ROWS     = 22;
   localparam bit [63:0] ONE_Q60 = 64'd1 << 60;
   localparam logic [OW-1:0] Q_ONE  = OW'(1) << FRAC;
   localparam logic [OW-1:0] Q_ZERO = '0;

   typedef struct packed {
      logic [7:0]        prefix_first;
      logic [7:0]        prefix_second;
      logic [7:0]        prefix_third;
      logic [7:0]        prefix_mode;
      logic signed [7:0] fine_first;
      logic signed [7:0] fine_second;
      logic signed [7:0] fine_third;
   } key_t;

   typedef struct packed {
      logic [OW-1:0] x;
      logic [OW-1:0] y;
      logic [OW-1:0] z;
      logic [OW-1:0] w;
   } quat_t;

   typedef struct packed {
      key_t  key;
      bit    has_want;
      quat_t want;
   } stim_row_t;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [7:0]          req_prefix_first;
   logic [7:0]          req_prefix_second;
   logic [7:0]          req_prefix_third;
   logic [7:0]          req_prefix_mode;
   logic signed [7:0]   req_fine_first;
   logic signed [7:0]   req_fine_second;
   logic signed [7:0]   req_fine_third;
   logic                rsp_valid;
   logic [OW-1:0]       rsp_quat_x;
   logic [OW-1:0]       rsp_quat_y;
   logic [OW-1:0]       rsp_quat_z;
   logic [OW-1:0]       rsp_quat_w;

   quat_t expected_quats[$];
   int    fail_count   = 0;
   int    keys_sent    = 0;
   int    quats_checked = 0;
   int    raw_keys     = 0;
   int    shaped_keys  = 0;
   int    stall_cycles = 0;

   smallest_three_quat_dequant_core uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_prefix_first  (req_prefix_first),
      .req_prefix_second (req_prefix_second),
      .req_prefix_third  (req_prefix_third),
      .req_prefix_mode   (req_prefix_mode),
      .req_fine_first    (req_fine_first),
      .req_fine_second   (req_fine_second),
      .req_fine_third    (req_fine_third),
      .rsp_valid         (rsp_valid),
      .rsp_quat_x        (rsp_quat_x),
      .rsp_quat_y        (rsp_quat_y),
      .rsp_quat_z        (rsp_quat_z),
      .rsp_quat_w        (rsp_quat_w)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Edge cases. Only the keys whose kept components decode to zero have results
   // typed in: the dropped component is exactly one and the kept ones are zero.
   stim_row_t dir_rows [ROWS] = '{
      '{'{8'h00, 8'h00, 8'h00, 8'hC0, 8'sh00, 8'sh00, 8'sh00}, 1'b1,
        '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE}},
      '{'{8'h00, 8'h00, 8'h00, 8'h00, 8'sh00, 8'sh00, 8'sh00}, 1'b1,
        '{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}},
      '{'{8'h00, 8'h00, 8'h00, 8'h40, 8'sh00, 8'sh00, 8'sh00}, 1'b1,
        '{Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO}},
      '{'{8'h00, 8'h00, 8'h00, 8'h80, 8'sh00, 8'sh00, 8'sh00}, 1'b1,
        '{Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO}},
      '{'{8'h00, 8'h00, 8'h00, 8'hFF, 8'sh00, 8'sh00, 8'sh00}, 1'b1,
        '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE}},
      '{'{8'h00, 8'h00, 8'h00, 8'h3F, 8'sh00, 8'sh00, 8'sh00}, 1'b1,
        '{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}},
      '{'{8'h80, 8'h80, 8'h80, 8'hD5, 8'sh00, 8'sh00, 8'sh00}, 1'b1,
        '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE}},
      '{'{8'h3F, 8'h3F, 8'h3F, 8'hC0, 8'sh7F, 8'sh7F, 8'sh7F}, 1'b0, '0},
      '{'{8'hBF, 8'hBF, 8'hBF, 8'h00, 8'sh7F, 8'sh7F, 8'sh7F}, 1'b0, '0},
      '{'{8'h40, 8'h40, 8'h40, 8'h40, -8'sd128, -8'sd128, -8'sd128}, 1'b0, '0},
      '{'{8'hC0, 8'hC0, 8'hC0, 8'hC0, -8'sd128, -8'sd128, -8'sd128}, 1'b0, '0},
      '{'{8'h3F, 8'h40, 8'h00, 8'h80, 8'sh7F, -8'sd128, 8'sh00}, 1'b0, '0},
      '{'{8'hBF, 8'hC0, 8'h80, 8'h2A, -8'sd128, 8'sh7F, 8'sh01}, 1'b0, '0},
      '{'{8'h7F, 8'hFF, 8'h7F, 8'hC0, 8'sh7F, -8'sd1, -8'sd1}, 1'b0, '0},
      '{'{8'h80, 8'h00, 8'h80, 8'h40, -8'sd1, 8'sh01, 8'sh01}, 1'b0, '0},
      '{'{8'h20, 8'h20, 8'h20, 8'hC0, 8'sh00, 8'sh00, 8'sh00}, 1'b0, '0},
      '{'{8'h2D, 8'h2D, 8'h00, 8'hC0, 8'sh41, 8'sh41, 8'sh00}, 1'b0, '0},
      '{'{8'h10, 8'hF0, 8'h25, 8'h00, 8'sh33, -8'sd77, 8'sh12}, 1'b0, '0},
      '{'{8'h10, 8'hF0, 8'h25, 8'h40, 8'sh33, -8'sd77, 8'sh12}, 1'b0, '0},
      '{'{8'h10, 8'hF0, 8'h25, 8'h80, 8'sh33, -8'sd77, 8'sh12}, 1'b0, '0},
      '{'{8'h10, 8'hF0, 8'h25, 8'hFF, 8'sh33, -8'sd77, 8'sh12}, 1'b0, '0},
      '{'{8'h5A, 8'hA5, 8'h6C, 8'h93, 8'sh55, -8'sd86, 8'sh2B}, 1'b0, '0}
   };

   function automatic bit [63:0] int_sqrt(input bit [63:0] v);
      bit [63:0] r;
      bit [63:0] trial;
      int        b;
      r = '0;
      for (b = 31; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= v) r = trial;
      end
      return r;
   endfunction

   function automatic quat_t dequant_key(input key_t k);
      logic [7:0]        pre [3];
      logic signed [7:0] fin [3];
      longint            coarse;
      longint            fine_v;
      longint            n_val;
      bit [63:0]         n_mag;
      bit [63:0]         prod;
      bit [63:0]         c30;
      bit [63:0]         mag_r;
      bit [63:0]         sum_sq;
      bit [63:0]         rem;
      bit [63:0]         root;
      logic [OW-1:0]     kept_mag;
      logic [OW-1:0]     kept [3];
      logic [OW-1:0]     drop_val;
      quat_t             q;
      int                i;
      pre = '{k.prefix_first, k.prefix_second, k.prefix_third};
      fin = '{k.fine_first, k.fine_second, k.fine_third};
      sum_sq = '0;
      for (i = 0; i < 3; i++) begin
         coarse = longint'($signed(pre[i][6:0]));
         fine_v = longint'(fin[i]);
         n_val  = coarse * 256 + fine_v * (pre[i][7] ? 8 : 1);
         n_mag  = (n_val < 0) ? -n_val : n_val;
         prod   = n_mag * 64'(SQRT_HALF_Q32);
         // The remainder is built from Q.30 copies of the kept components.
         c30    = (prod + (64'd1 << 15)) >> 16;
         sum_sq += c30 * c30;
         mag_r  = (prod + (64'd1 << (KEPT_SH - 1))) >> KEPT_SH;
         kept_mag = mag_r[OW-1:0];
         kept[i]  = (n_val < 0) ? -kept_mag : kept_mag;
      end
      rem  = (sum_sq < ONE_Q60) ? ONE_Q60 - sum_sq : 64'd0;
      root = int_sqrt(rem >> ROOT_SH);
      // Round the root to nearest; a tie goes up.
      if (rem >= (((root * root) + root) << ROOT_SH) + (64'd1 << (ROOT_SH - 2)))
         root = root + 1;
      drop_val = root[OW-1:0];
      case (drop_type'(k.prefix_mode[7:6]))
         DROP_X:  q = '{x: drop_val, y: kept[0], z: kept[1], w: kept[2]};
         DROP_Y:  q = '{x: kept[0], y: drop_val, z: kept[1], w: kept[2]};
         DROP_Z:  q = '{x: kept[0], y: kept[1], z: drop_val, w: kept[2]};
         default: q = '{x: kept[0], y: kept[1], z: kept[2], w: drop_val};
      endcase
      return q;
   endfunction

   function automatic logic [7:0] prefix_byte(input int lim);
      int c;
      c = int'($urandom_range(0, 2 * lim - 1)) - lim;
      return {1'($urandom_range(0, 1)), 7'(c)};
   endfunction

   // Most keys look like real stream data: kept components small enough that
   // the remainder stays positive, some near the unit-norm edge, the rest raw.
   function automatic key_t random_key(input int kind);
      key_t k;
      int   lim;
      k = key_t'(56'({$urandom, $urandom}));
      if (kind != 0) begin
         lim = (kind == 3) ? 48 : 24;
         k.prefix_first  = prefix_byte(lim);
         k.prefix_second = prefix_byte(lim);
         k.prefix_third  = prefix_byte(lim);
      end
      return k;
   endfunction

   function automatic int pick_gap(input bit burst);
      int r;
      if (burst) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 45) return 0;
      if (r < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   task automatic send_key(input key_t k, input quat_t want, input int gap);
      @(negedge clock);
      start             <= 1'b1;
      req_prefix_first  <= k.prefix_first;
      req_prefix_second <= k.prefix_second;
      req_prefix_third  <= k.prefix_third;
      req_prefix_mode   <= k.prefix_mode;
      req_fine_first    <= k.fine_first;
      req_fine_second   <= k.fine_second;
      req_fine_third    <= k.fine_third;
      do @(posedge clock); while (busy !== 1'b0);
      expected_quats.insert(expected_quats.size(), want);
      keys_sent++;
      // Junk on the request fields while start is low must be ignored.
      repeat (gap) begin
         @(negedge clock);
         start             <= 1'b0;
         req_prefix_first  <= 8'($urandom);
         req_prefix_second <= 8'($urandom);
         req_prefix_third  <= 8'($urandom);
         req_prefix_mode   <= 8'($urandom);
         req_fine_first    <= 8'($urandom);
         req_fine_second   <= 8'($urandom);
         req_fine_third    <= 8'($urandom);
      end
   endtask

   function automatic void check_field(input string name, input logic [OW-1:0] want,
                                       input logic [OW-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         fail_count++;
      end
   endfunction

   // One result beat per cycle at most; compare it with the oldest key.
   always @(posedge clock) begin
      quat_t want;
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (expected_quats.size() == 0) begin
            $error("unexpected result beat: x=%0d y=%0d z=%0d w=%0d",
                   $signed(rsp_quat_x), $signed(rsp_quat_y),
                   $signed(rsp_quat_z), $signed(rsp_quat_w));
            fail_count++;
         end else begin
            want = expected_quats.pop_front();
            check_field("quat_x", want.x, rsp_quat_x);
            check_field("quat_y", want.y, rsp_quat_y);
            check_field("quat_z", want.z, rsp_quat_z);
            check_field("quat_w", want.w, rsp_quat_w);
            quats_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("** smallest_three_quat_dequant_core: FAILED **");
         $finish;
      end
   end

   initial begin
      key_t k;
      int   n;
      int   kind;
      bit   burst;
      reset             = 1'b1;
      start             = 1'b0;
      req_prefix_first  = '0;
      req_prefix_second = '0;
      req_prefix_third  = '0;
      req_prefix_mode   = '0;
      req_fine_first    = '0;
      req_fine_second   = '0;
      req_fine_third    = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < ROWS; n++) begin
         send_key(dir_rows[n].key,
                  dir_rows[n].has_want ? dir_rows[n].want : dequant_key(dir_rows[n].key),
                  pick_gap(n < 8));
      end

      for (n = 0; n < RANDOM_KEYS; n++) begin
         burst = ((n / 64) % 3) == 1;
         kind  = int'($urandom_range(0, 3));
         if (kind == 0) raw_keys++;
         else shaped_keys++;
         k = random_key(kind);
         send_key(k, dequant_key(k), pick_gap(burst));
      end

      @(negedge clock);
      start <= 1'b0;
      while (expected_quats.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      if (expected_quats.size() != 0) begin
         $error("%0d expected results never arrived", expected_quats.size());
         fail_count++;
      end
      $display("covered %0d keys: %0d edge cases, %0d shaped and %0d raw random",
               keys_sent, ROWS, shaped_keys, raw_keys);
      $display("%0d result beats compared, %0d mismatches", quats_checked, fail_count);
      if (fail_count == 0) begin
         $display("** smallest_three_quat_dequant_core: PASSED **");
      end else begin
         $display("** smallest_three_quat_dequant_core: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
